// File: rtl/core/assert_macros.svh
// Assertion macros used by the replacer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/core/lruk_pkg.sv
// Package with widths, codes and the request layout of the LRU-K replacer.
`timescale 1ns / 1ps
package lruk_pkg;
    localparam int ENTRIES  = 16;
    localparam int K_MAX    = 4;
    localparam int TS_WIDTH = 48;
    localparam int SLOT_W   = $clog2(ENTRIES);
    localparam int KIDX_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CNT_W    = $clog2(K_MAX + 1);
    localparam int EVC_W    = $clog2(ENTRIES + 1);
    localparam int HIST_W   = K_MAX * TS_WIDTH;

    typedef enum logic [1:0] {
        FUNC_ACCESS = 2'd0,
        FUNC_SET_EVICT = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_EVICT = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_NOT_EVICTABLE = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_NO_VICTIM = 3'd4,
        ST_CLOCK_EXHAUSTED = 3'd5
    } status_t;
endpackage

// File: rtl/core/lru_k_page_replacer_unit.sv
// LRU-K page replacer: slot table in registers, timestamp histories in a memory.
`timescale 1ns / 1ps
// Usage: a request enters on s_axis (tdata = func, page_id, make_evictable from
// the lowest bit up). Exactly one response leaves on m_axis per request
// (tdata = status, evicted_page, evictable_count from the lowest bit up).
// A write on cfg_valid/cfg_ready sets K (history_depth, reset value 2); it is
// taken only while no request is in flight.
// Every request scans all ENTRIES slots, one slot per cycle, and also reads
// each slot's timestamps from the history memory for the victim ranking. The
// ranking of the last slot extends the scan when that slot is evictable. Set
// evictable, remove and evict present their response after the scan and a
// decision step; access adds a history read and a write back before it.
// The response sits in an output register: while the receiver stalls, the
// block holds it and accepts no new request until it has been taken.
// Reset clears the slot valid bits, flags, counts, the access clock and the
// evictable total at once; no clearing pass is needed since histories are only
// used for valid slots.
module lru_k_page_replacer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // func[1:0], page_id[33:2], make_evictable[34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status[2:0], evicted_page[34:3], count[39:35]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);
    import lruk_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_HREAD, S_WRITE, S_RESP} state_t;

    state_t state_reg;
    logic [2:0] k_reg;
    logic [ENTRIES-1:0] valid_reg, evict_reg;
    logic [CNT_W-1:0] cnt_reg [ENTRIES];
    logic [31:0] page_mem [ENTRIES];
    logic [HIST_W-1:0] hist_mem [ENTRIES];
    logic [HIST_W-1:0] hist_rd;
    logic [TS_WIDTH-1:0] clock_reg;
    logic [EVC_W-1:0] evtot_reg;

    func_t func_reg;
    logic [31:0] page_reg;
    logic make_reg;
    logic [SLOT_W:0] idx_reg;         // scan counter, can hold ENTRIES
    logic hit_reg, free_reg;
    logic [SLOT_W-1:0] hit_slot_reg, free_slot_reg;
    // Victim search state.
    logic best_reg, best_cls_reg;
    logic [TS_WIDTH-1:0] best_ts_reg;
    logic [SLOT_W-1:0] best_slot_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic rd_pend_reg;
    logic [2:0] status_reg;
    logic [31:0] victim_reg;
    logic [2:0] keff;
    logic [SLOT_W-1:0] idx;

    assign idx = idx_reg[SLOT_W-1:0];
    assign keff = (k_reg == 3'd0) ? 3'd1 :
                  (32'(k_reg) > K_MAX) ? 3'(K_MAX) : k_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !s_axis_tvalid;
    assign m_axis_tvalid = (state_reg == S_RESP);
    assign m_axis_tdata = {evtot_reg, victim_reg, status_reg};

    // Rank key of the slot whose history was read last cycle.
    logic [CNT_W-1:0] rcnt;
    logic rcls;
    logic [KIDX_W-1:0] rsel;
    logic [TS_WIDTH-1:0] rts;
    always_comb
    begin
        rcnt = (cnt_reg[rd_slot_reg] == '0) ? CNT_W'(1) : cnt_reg[rd_slot_reg];
        if (32'(rcnt) < 32'(keff))
        begin
            rcls = 1'b0;
            rsel = KIDX_W'(rcnt - CNT_W'(1));
        end
        else
        begin
            rcls = 1'b1;
            rsel = KIDX_W'(keff - 3'd1);
        end
        rts = hist_rd[rsel*TS_WIDTH +: TS_WIDTH];
    end

    // History memory: one read and one write port, registered read.
    logic hist_we;
    logic [SLOT_W-1:0] hist_waddr, hist_raddr;
    logic [HIST_W-1:0] hist_wdata;
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        hist_rd <= hist_mem[hist_raddr];
    end
    always_comb
    begin
        hist_raddr = (state_reg == S_SCAN) ? idx :
                     (hit_reg ? hit_slot_reg : free_slot_reg);
        hist_we = (state_reg == S_WRITE);
        hist_waddr = hit_reg ? hit_slot_reg : free_slot_reg;
        if (hit_reg)
            hist_wdata = {hist_rd[HIST_W-TS_WIDTH-1:0], clock_reg};
        else
            hist_wdata = {{(HIST_W-TS_WIDTH){1'b0}}, clock_reg};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            page_reg <= s_axis_tdata[33:2];
            make_reg <= s_axis_tdata[34];
        end
        if (state_reg == S_WRITE && !hit_reg)
            page_mem[free_slot_reg] <= page_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg <= 3'd2;
            valid_reg <= '0;
            evict_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
                cnt_reg[i] <= '0;
            clock_reg <= '0;
            evtot_reg <= '0;
            func_reg <= FUNC_ACCESS;
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            hit_slot_reg <= '0;
            free_slot_reg <= '0;
            best_reg <= 1'b0;
            best_cls_reg <= 1'b0;
            best_ts_reg <= '0;
            best_slot_reg <= '0;
            rd_slot_reg <= '0;
            rd_pend_reg <= 1'b0;
            status_reg <= ST_OK;
            victim_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                        k_reg <= cfg_data;
                    if (s_axis_tvalid)
                    begin
                        func_reg <= func_t'(s_axis_tdata[1:0]);
                        idx_reg <= '0;
                        hit_reg <= 1'b0;
                        free_reg <= 1'b0;
                        best_reg <= 1'b0;
                        rd_pend_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // Lookup and free-slot search, one slot per cycle.
                    if (idx_reg < (SLOT_W+1)'(ENTRIES))
                    begin
                        if (valid_reg[idx] && page_mem[idx] == page_reg && !hit_reg)
                        begin
                            hit_reg <= 1'b1;
                            hit_slot_reg <= idx;
                        end
                        if (!valid_reg[idx] && !free_reg)
                        begin
                            free_reg <= 1'b1;
                            free_slot_reg <= idx;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                    // Victim ranking on the history read issued last cycle.
                    rd_slot_reg <= idx;
                    rd_pend_reg <= (idx_reg < (SLOT_W+1)'(ENTRIES)) &&
                                   valid_reg[idx] && evict_reg[idx];
                    if (rd_pend_reg)
                    begin
                        if (!best_reg || rcls < best_cls_reg ||
                            (rcls == best_cls_reg && rts < best_ts_reg))
                        begin
                            best_reg <= 1'b1;
                            best_cls_reg <= rcls;
                            best_ts_reg <= rts;
                            best_slot_reg <= rd_slot_reg;
                        end
                    end
                    if (idx_reg == (SLOT_W+1)'(ENTRIES) && !rd_pend_reg)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    case (func_reg)
                        FUNC_ACCESS:
                        begin
                            victim_reg <= '0;
                            if (clock_reg == {TS_WIDTH{1'b1}})
                            begin
                                status_reg <= ST_CLOCK_EXHAUSTED;
                                state_reg <= S_RESP;
                            end
                            else if (!hit_reg && !free_reg)
                            begin
                                status_reg <= ST_TABLE_FULL;
                                state_reg <= S_RESP;
                            end
                            else
                            begin
                                status_reg <= ST_OK;
                                clock_reg <= clock_reg + 1'b1;
                                state_reg <= S_HREAD;
                            end
                        end
                        FUNC_SET_EVICT:
                        begin
                            victim_reg <= '0;
                            state_reg <= S_RESP;
                            if (!hit_reg)
                                status_reg <= ST_NOT_FOUND;
                            else
                            begin
                                status_reg <= ST_OK;
                                if (evict_reg[hit_slot_reg] != make_reg)
                                begin
                                    evict_reg[hit_slot_reg] <= make_reg;
                                    if (make_reg)
                                        evtot_reg <= evtot_reg + 1'b1;
                                    else if (evtot_reg != '0)
                                        evtot_reg <= evtot_reg - 1'b1;
                                end
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            victim_reg <= '0;
                            state_reg <= S_RESP;
                            if (!hit_reg)
                                status_reg <= ST_NOT_FOUND;
                            else if (!evict_reg[hit_slot_reg])
                                status_reg <= ST_NOT_EVICTABLE;
                            else
                            begin
                                status_reg <= ST_OK;
                                valid_reg[hit_slot_reg] <= 1'b0;
                                evict_reg[hit_slot_reg] <= 1'b0;
                                cnt_reg[hit_slot_reg] <= '0;
                                if (evtot_reg != '0)
                                    evtot_reg <= evtot_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_RESP;
                            if (!best_reg)
                            begin
                                status_reg <= ST_NO_VICTIM;
                                victim_reg <= '0;
                            end
                            else
                            begin
                                status_reg <= ST_OK;
                                victim_reg <= page_mem[best_slot_reg];
                                valid_reg[best_slot_reg] <= 1'b0;
                                evict_reg[best_slot_reg] <= 1'b0;
                                cnt_reg[best_slot_reg] <= '0;
                                if (evtot_reg != '0)
                                    evtot_reg <= evtot_reg - 1'b1;
                            end
                        end
                    endcase
                end
                S_HREAD:
                    // The history read for the target slot is issued here.
                    state_reg <= S_WRITE;
                S_WRITE:
                begin
                    if (hit_reg)
                    begin
                        if (32'(cnt_reg[hit_slot_reg]) < K_MAX)
                            cnt_reg[hit_slot_reg] <= cnt_reg[hit_slot_reg] + 1'b1;
                    end
                    else
                    begin
                        valid_reg[free_slot_reg] <= 1'b1;
                        evict_reg[free_slot_reg] <= 1'b1;
                        cnt_reg[free_slot_reg] <= CNT_W'(1);
                        evtot_reg <= evtot_reg + 1'b1;
                    end
                    state_reg <= S_RESP;
                end
                S_RESP:
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_cnt_le_entries, clk, rst_n, 1'b1,
        32'(evtot_reg) == 32'($countones(valid_reg & evict_reg)),
        "evictable total disagrees with slot flags")
    `ASSERT_IMPL(a_evict_implies_valid, clk, rst_n, 1'b1,
        (evict_reg & ~valid_reg) == '0, "evictable flag on free slot")
    `ASSERT_NEXT(a_resp_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "response changed while stalled")
endmodule

// File: tb/lruk_checker.sv
// Checker that predicts LRU-K replacer responses and compares them with the block's output.
`timescale 1ns / 1ps
module lruk_checker
    import lruk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          responses_seen
);
    // Packed from the top bit down, so status lands in the lowest bits.
    typedef struct packed {
        logic [4:0]  evictable;
        logic [31:0] victim;
        status_t     status;
    } response_t;

    logic [2:0]          depth_reg;
    logic                slot_used [ENTRIES];
    logic [31:0]         slot_page [ENTRIES];
    logic                slot_evictable [ENTRIES];
    int                  slot_hits [ENTRIES];
    logic [TS_WIDTH-1:0] slot_stamps [ENTRIES][K_MAX];
    logic [TS_WIDTH-1:0] stamp_clock;
    int                  evictable_now;
    response_t           expected_responses [$];

    assign pending = expected_responses.size();

    function automatic int lookup_page(logic [31:0] page);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_page[i] == page) return i;
        return -1;
    endfunction

    function automatic void release_slot(int s);
        slot_used[s] = 1'b0;
        if (slot_evictable[s] && evictable_now > 0) evictable_now--;
        slot_evictable[s] = 1'b0;
        slot_hits[s] = 0;
    endfunction

    function automatic response_t predict_response(logic [39:0] req);
        func_t       op;
        logic [31:0] page;
        logic        make;
        response_t   r;
        int          s;
        int          k;
        int          best;
        int          cls;
        int          best_cls;
        int          cnt;
        logic [TS_WIDTH-1:0] ts;
        logic [TS_WIDTH-1:0] best_ts;
        op = func_t'(req[1:0]);
        page = req[33:2];
        make = req[34];
        r.status = ST_OK;
        r.victim = '0;
        case (op)
            FUNC_ACCESS:
            begin
                s = lookup_page(page);
                if (stamp_clock == {TS_WIDTH{1'b1}}) r.status = ST_CLOCK_EXHAUSTED;
                else if (s < 0)
                begin
                    for (int j = 0; j < ENTRIES; j++)
                        if (!slot_used[j] && s < 0) s = j;
                    if (s < 0) r.status = ST_TABLE_FULL;
                    else
                    begin
                        stamp_clock++;
                        slot_used[s] = 1'b1;
                        slot_page[s] = page;
                        slot_evictable[s] = 1'b1;
                        slot_hits[s] = 1;
                        slot_stamps[s][0] = stamp_clock;
                        evictable_now++;
                    end
                end
                else
                begin
                    stamp_clock++;
                    for (int j = K_MAX - 1; j > 0; j--)
                        slot_stamps[s][j] = slot_stamps[s][j-1];
                    slot_stamps[s][0] = stamp_clock;
                    if (slot_hits[s] < K_MAX) slot_hits[s]++;
                end
            end
            FUNC_SET_EVICT:
            begin
                s = lookup_page(page);
                if (s < 0) r.status = ST_NOT_FOUND;
                else if (slot_evictable[s] != make)
                begin
                    slot_evictable[s] = make;
                    if (make) evictable_now++;
                    else if (evictable_now > 0) evictable_now--;
                end
            end
            FUNC_REMOVE:
            begin
                s = lookup_page(page);
                if (s < 0) r.status = ST_NOT_FOUND;
                else if (!slot_evictable[s]) r.status = ST_NOT_EVICTABLE;
                else release_slot(s);
            end
            default:
            begin
                // Out-of-range K folds to the nearest legal value.
                k = (depth_reg == 0) ? 1 : (depth_reg > K_MAX) ? K_MAX : depth_reg;
                best = -1;
                best_cls = 0;
                best_ts = '0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_used[i] && slot_evictable[i])
                    begin
                        cnt = (slot_hits[i] == 0) ? 1 : slot_hits[i];
                        if (cnt < k)
                        begin
                            cls = 0;
                            ts = slot_stamps[i][cnt-1];
                        end
                        else
                        begin
                            cls = 1;
                            ts = slot_stamps[i][k-1];
                        end
                        if (best < 0 || cls < best_cls || (cls == best_cls && ts < best_ts))
                        begin
                            best = i;
                            best_cls = cls;
                            best_ts = ts;
                        end
                    end
                end
                if (best < 0) r.status = ST_NO_VICTIM;
                else
                begin
                    r.victim = slot_page[best];
                    release_slot(best);
                end
            end
        endcase
        r.evictable = evictable_now[4:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        response_t got;
        if (!rst_n)
        begin
            depth_reg = 3'd2;
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_used[i] = 1'b0;
                slot_evictable[i] = 1'b0;
                slot_hits[i] = 0;
                slot_page[i] = '0;
                for (int j = 0; j < K_MAX; j++) slot_stamps[i][j] = '0;
            end
            stamp_clock = '0;
            evictable_now = 0;
            fail_count = 0;
            responses_seen = 0;
            expected_responses.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready) depth_reg = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                expected_responses.push_back(predict_response(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                responses_seen++;
                if (expected_responses.size() == 0)
                begin
                    $error("response with nothing expected: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (got.evictable !== want.evictable)
                    begin
                        $error("evictable_count expected %0d got %0d", want.evictable,
                               got.evictable);
                        fail_count++;
                    end
                    if (got.victim !== want.victim)
                    begin
                        $error("evicted_page expected %h got %h", want.victim, got.victim);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// File: tb/tb_top.sv
// Top-level testbench for the LRU-K page replacer: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
    import lruk_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;
    int          fail_count;
    int          pending;
    int          responses_seen;
    int          cycle_count;
    int          requests_sent;
    logic [31:0] page_pool [8];

    // Generous cap: covers about 1300 requests with their sender gaps and
    // receiver stalls several times over.
    localparam int CYCLE_LIMIT = 400000;

    lru_k_page_replacer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),   // func, page_id, make_evictable
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),   // status, evicted_page, evictable_count
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    lruk_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .responses_seen(responses_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on total cycles; a hang anywhere ends in a failure verdict.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("[lru_k_page_replacer_unit] ERROR");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The receiver stalls on its own schedule, independent of the sender.
    initial
    begin
        int hold;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_axis_tready <= 1'b1;
            hold = $urandom_range(1, 30);
            repeat (hold) @(posedge clk);
            hold = gap_length();
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // Sends one request and waits for its acceptance; a gap may follow.
    task automatic send_request(func_t op, logic [31:0] page, logic make, bit allow_gap);
        int pause;
        s_axis_tdata <= {5'd0, make, page, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        requests_sent++;
        pause = allow_gap ? gap_length() : 0;
        if (pause > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    // Waits for the block to go idle, then writes K.
    task automatic write_depth(logic [2:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random request mostly against a small page pool so hits, evictions and
    // a full table all happen; others go to pages 0 to 19 or fully random numbers.
    task automatic random_request();
        func_t       op;
        logic [31:0] page;
        int          roll;
        roll = $urandom_range(0, 99);
        op = (roll < 50) ? FUNC_ACCESS : (roll < 65) ? FUNC_SET_EVICT :
             (roll < 78) ? FUNC_REMOVE : FUNC_EVICT;
        page = ($urandom_range(0, 9) == 0) ? $urandom() : page_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 3) == 0) page = $urandom_range(0, 19);
        send_request(op, page, 1'($urandom_range(0, 1)), 1'b1);
    endtask

    initial
    begin
        logic [2:0] depth_plan [6];
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = 3'd0;
        requests_sent = 0;
        depth_plan = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2};
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: evict from an empty table, unknown pages, pinned removal,
        // the widest page numbers and filling past the table size.
        send_request(FUNC_EVICT, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_request(FUNC_REMOVE, 32'h0000_0000, 1'b0, 1'b0);
        send_request(FUNC_SET_EVICT, 32'hDEAD_BEEF, 1'b1, 1'b0);
        send_request(FUNC_ACCESS, 32'h0000_0000, 1'b0, 1'b0);
        send_request(FUNC_ACCESS, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_request(FUNC_ACCESS, 32'h0000_0000, 1'b0, 1'b0);
        send_request(FUNC_SET_EVICT, 32'h0000_0000, 1'b0, 1'b0);
        send_request(FUNC_REMOVE, 32'h0000_0000, 1'b1, 1'b0);
        send_request(FUNC_SET_EVICT, 32'h0000_0000, 1'b0, 1'b0);
        send_request(FUNC_EVICT, 32'h0, 1'b0, 1'b0);
        for (int i = 0; i < 17; i++)
            send_request(FUNC_ACCESS, 32'h5555_0000 + i, 1'b0, 1'b0);
        send_request(FUNC_SET_EVICT, 32'h0000_0000, 1'b1, 1'b0);
        send_request(FUNC_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0);

        // Pause the sender until every response is back, then set K to 3.
        write_depth(3'd3);

        // Random phases under K settings 3, 1, 4, 0, 7 and 3; K ends at 2.
        for (int phase = 0; phase < 6; phase++)
        begin
            for (int p = 0; p < 8; p++) page_pool[p] = $urandom();
            repeat (205) random_request();
            write_depth(depth_plan[phase]);
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d requests and checked %0d responses over K settings 0 to 7,",
                 requests_sent, responses_seen);
        $display("covering hits, full table, pinning, removal and eviction ranking.");
        if (fail_count == 0 && pending == 0)
            $display("[lru_k_page_replacer_unit] OK");
        else
            $display("[lru_k_page_replacer_unit] ERROR");
        $finish;
    end
endmodule
